// ----- src/irc_line_tokenizer_macros.svh -----
// Assertion macros shared by the IRC line tokenizer RTL.
`ifndef IRC_LINE_TOKENIZER_MACROS_SVH
`define IRC_LINE_TOKENIZER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define IRCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// When ante holds at one edge, cons must hold at the next edge.
`define IRCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/irct_pkg.sv -----
// Types, codes and constants for the IRC line tokenizer.
package irct_pkg;

   localparam int unsigned MAX_ARGS = 15;

   localparam logic [7:0] COLON = 8'h3A;

   localparam logic [2:0] CLS_SKIP  = 3'd0;
   localparam logic [2:0] CLS_SRC   = 3'd1;
   localparam logic [2:0] CLS_CMD   = 3'd2;
   localparam logic [2:0] CLS_MID   = 3'd3;
   localparam logic [2:0] CLS_TRAIL = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NO_CMD    = 2'd2;

   localparam logic [3:0] MAX_ARGS_VAL = 4'(MAX_ARGS);

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_PREFIX = 3'd1,
      PH_PRECMD = 3'd2,
      PH_CMD    = 3'd3,
      PH_ARGWS  = 3'd4,
      PH_MIDDLE = 3'd5,
      PH_TRAIL  = 3'd6,
      PH_IGNORE = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0] token_class;
      logic [3:0] arg_index;
      logic [7:0] out_byte;
      logic       line_done;
      logic [1:0] status;
      logic [3:0] arg_count;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] args_seen;
   } parse_state_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
   endfunction

endpackage

// ----- src/irct_step.sv -----
// Next-state and tagging logic for one byte of an IRC line.
module irct_step import irct_pkg::*; (
   input  parse_state_type cur,
   input  req_type         req_item,
   output parse_state_type nxt,
   output rsp_type         rsp_item
);

   logic            ws;
   logic [7:0]      b;
   parse_state_type mid;
   logic [3:0]      prev_idx;

   always_comb begin
      b        = req_item.in_byte;
      ws       = is_ws(b);
      prev_idx = cur.args_seen - 4'd1;
      mid      = cur;
      rsp_item = '0;
      rsp_item.token_class = CLS_SKIP;
      rsp_item.out_byte    = b;
      rsp_item.line_done   = req_item.last;

      case (cur.phase)
         PH_LEAD: begin
            if (ws) begin
               mid.phase = PH_LEAD;
            end else if (b == COLON) begin
               mid.phase = PH_PREFIX;
            end else begin
               rsp_item.token_class = CLS_CMD;
               rsp_item.out_byte    = upcase(b);
               mid.phase            = PH_CMD;
            end
         end
         PH_PREFIX: begin
            if (ws) begin
               mid.phase = PH_PRECMD;
            end else begin
               rsp_item.token_class = CLS_SRC;
            end
         end
         PH_PRECMD: begin
            if (!ws) begin
               rsp_item.token_class = CLS_CMD;
               rsp_item.out_byte    = upcase(b);
               mid.phase            = PH_CMD;
            end
         end
         PH_CMD: begin
            if (ws) begin
               mid.phase = PH_ARGWS;
            end else begin
               rsp_item.token_class = CLS_CMD;
               rsp_item.out_byte    = upcase(b);
            end
         end
         PH_ARGWS: begin
            if (ws) begin
               mid.phase = PH_ARGWS;
            end else if (cur.args_seen >= MAX_ARGS_VAL) begin
               mid.phase = PH_IGNORE;
            end else if (b == COLON) begin
               // delimiting colon opens the trailing argument
               mid.args_seen = cur.args_seen + 4'd1;
               mid.phase     = PH_TRAIL;
            end else begin
               rsp_item.token_class = CLS_MID;
               rsp_item.arg_index   = cur.args_seen;
               mid.args_seen        = cur.args_seen + 4'd1;
               mid.phase            = PH_MIDDLE;
            end
         end
         PH_MIDDLE: begin
            if (ws) begin
               mid.phase = PH_ARGWS;
            end else begin
               rsp_item.token_class = CLS_MID;
               rsp_item.arg_index   = prev_idx;
            end
         end
         PH_TRAIL: begin
            rsp_item.token_class = CLS_TRAIL;
            rsp_item.arg_index   = prev_idx;
         end
         PH_IGNORE: begin
            mid.phase = PH_IGNORE;
         end
         default: begin
            mid.phase = PH_IGNORE;
         end
      endcase

      nxt = mid;
      if (req_item.last) begin
         // status follows the phase reached after this byte
         if (mid.phase == PH_LEAD) begin
            rsp_item.status = ST_EMPTY;
         end else if ((mid.phase == PH_PREFIX) || (mid.phase == PH_PRECMD)) begin
            rsp_item.status = ST_NO_CMD;
         end else begin
            rsp_item.status    = ST_OK;
            rsp_item.arg_count = mid.args_seen;
         end
         nxt.phase     = PH_LEAD;
         nxt.args_seen = 4'd0;
      end
   end

endmodule

// ----- src/irc_line_tokenizer.sv -----
// Top level of the IRC line tokenizer: parse state and result register.
// Latency: a byte accepted at one edge shows its result from the next cycle on.
// Throughput: one byte per cycle while the result is being taken; the only loop is the phase/argument-count register.
// Reset clears the parse state to the leading-whitespace phase and empties the result.
`include "irc_line_tokenizer_macros.svh"

module irc_line_tokenizer import irct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_item_ff;
   rsp_type         rsp_item_in;
   rsp_type         step_rsp;
   logic            req_fire;

   irct_step u_step (
      .cur      (state_ff),
      .req_item (req_item),
      .nxt      (state_in),
      .rsp_item (step_rsp)
   );

   // take a new item whenever the result slot is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = step_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= PH_LEAD;
         state_ff.args_seen <= 4'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `IRCT_ASSERT(a_args_bound, state_ff.args_seen <= MAX_ARGS_VAL, "argument count past limit")
   `IRCT_ASSERT_NEXT(a_line_clear, req_fire && req_item.last, (state_ff.phase == PH_LEAD) && (state_ff.args_seen == 4'd0), "state not cleared after last byte")
   `IRCT_ASSERT_NEXT(a_fire_result, req_fire, rsp_valid_ff, "accepted item produced no result")
   `IRCT_ASSERT(a_count_ok_only, !rsp_valid_ff || (rsp_item_ff.status == ST_OK) || (rsp_item_ff.arg_count == 4'd0), "argument count on failed line")
   `IRCT_ASSERT(a_index_class, !rsp_valid_ff || (rsp_item_ff.token_class == CLS_MID) || (rsp_item_ff.token_class == CLS_TRAIL) || (rsp_item_ff.arg_index == 4'd0), "argument index outside argument")

endmodule

// ----- verif/irc_line_tokenizer_tb.sv -----
// Self-checking testbench for the IRC line tokenizer: directed lines, then random lines.
`timescale 1ns / 100ps

module irc_line_tokenizer_tb;
   import irct_pkg::*;

   typedef struct packed {
      req_type item;
      logic    typed;   // want holds the expected result for this row
      rsp_type want;
   } feed_row_type;

   localparam rsp_type NO_WANT = '0;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   // Row in flight on the input channel, moved along with req_item.
   logic    cur_typed = 1'b0;
   rsp_type cur_want = '0;

   feed_row_type byte_feed [$];
   rsp_type      pending_tags [$];
   int           mismatch_count = 0;

   int unsigned send_idle_pct = 26;
   int unsigned recv_idle_pct = 64;
   logic        sender_pause = 1'b0;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;

   // Tokenizer state as the predictor sees it.
   phase_type  tok_phase = PH_LEAD;
   logic [3:0] tok_args = '0;

   // Short lines with a lone byte first, then longer ones checked by the predictor.
   feed_row_type dir_rows [26] = '{
      {8'h20, 1'b1, 1'b1, {CLS_SKIP, 4'd0, 8'h20, 1'b1, ST_EMPTY, 4'd0}},
      {8'h3A, 1'b1, 1'b1, {CLS_SKIP, 4'd0, 8'h3A, 1'b1, ST_NO_CMD, 4'd0}},
      {8'hFF, 1'b1, 1'b1, {CLS_CMD, 4'd0, 8'hFF, 1'b1, ST_OK, 4'd0}},
      {8'h01, 1'b1, 1'b1, {CLS_CMD, 4'd0, 8'h01, 1'b1, ST_OK, 4'd0}},
      // prefix, colon inside the command, high byte in a middle argument, trailing
      {8'h3A, 1'b0, 1'b0, NO_WANT},
      {8'h6E, 1'b0, 1'b0, NO_WANT},
      {8'h09, 1'b0, 1'b0, NO_WANT},
      {8'h70, 1'b0, 1'b0, NO_WANT},
      {8'h69, 1'b0, 1'b0, NO_WANT},
      {8'h3A, 1'b0, 1'b0, NO_WANT},
      {8'h20, 1'b0, 1'b0, NO_WANT},
      {8'h61, 1'b0, 1'b0, NO_WANT},
      {8'h80, 1'b0, 1'b0, NO_WANT},
      {8'h20, 1'b0, 1'b0, NO_WANT},
      {8'h3A, 1'b0, 1'b0, NO_WANT},
      {8'h74, 1'b0, 1'b0, NO_WANT},
      {8'h20, 1'b0, 1'b0, NO_WANT},
      {8'h0D, 1'b1, 1'b0, NO_WANT},
      // empty prefix, then an empty trailing argument
      {8'h3A, 1'b0, 1'b0, NO_WANT},
      {8'h20, 1'b0, 1'b0, NO_WANT},
      {8'h71, 1'b0, 1'b0, NO_WANT},
      {8'h20, 1'b0, 1'b0, NO_WANT},
      {8'h3A, 1'b1, 1'b0, NO_WANT},
      // leading VT and FF, then a one-letter command
      {8'h0B, 1'b0, 1'b0, NO_WANT},
      {8'h0C, 1'b0, 1'b0, NO_WANT},
      {8'h7A, 1'b1, 1'b0, NO_WANT}
   };

   irc_line_tokenizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic [7:0] cmd_char(input logic [7:0] b);
      if ((b >= 8'h61) && (b <= 8'h7A)) return b - 8'h20;
      return b;
   endfunction

   // Tag one byte and advance the tokenizer state.
   function automatic rsp_type tokenize_byte(input req_type r);
      rsp_type    o;
      logic [7:0] b;
      logic       ws;
      b = r.in_byte;
      ws = is_space(b);
      o = '0;
      o.token_class = CLS_SKIP;
      o.out_byte = b;
      case (tok_phase)
         PH_LEAD: begin
            if (!ws) begin
               if (b == COLON) begin
                  tok_phase = PH_PREFIX;
               end else begin
                  o.token_class = CLS_CMD;
                  o.out_byte = cmd_char(b);
                  tok_phase = PH_CMD;
               end
            end
         end
         PH_PREFIX: begin
            if (ws) tok_phase = PH_PRECMD;
            else o.token_class = CLS_SRC;
         end
         PH_PRECMD: begin
            if (!ws) begin
               o.token_class = CLS_CMD;
               o.out_byte = cmd_char(b);
               tok_phase = PH_CMD;
            end
         end
         PH_CMD: begin
            if (ws) begin
               tok_phase = PH_ARGWS;
            end else begin
               o.token_class = CLS_CMD;
               o.out_byte = cmd_char(b);
            end
         end
         PH_ARGWS: begin
            if (!ws) begin
               if (tok_args >= MAX_ARGS_VAL) begin
                  tok_phase = PH_IGNORE;
               end else if (b == COLON) begin
                  tok_args = tok_args + 4'd1;
                  tok_phase = PH_TRAIL;
               end else begin
                  o.token_class = CLS_MID;
                  o.arg_index = tok_args;
                  tok_args = tok_args + 4'd1;
                  tok_phase = PH_MIDDLE;
               end
            end
         end
         PH_MIDDLE: begin
            if (ws) begin
               tok_phase = PH_ARGWS;
            end else begin
               o.token_class = CLS_MID;
               o.arg_index = tok_args - 4'd1;
            end
         end
         PH_TRAIL: begin
            o.token_class = CLS_TRAIL;
            o.arg_index = tok_args - 4'd1;
         end
         default: begin
         end
      endcase
      if (r.last) begin
         o.line_done = 1'b1;
         if (tok_phase == PH_LEAD) begin
            o.status = ST_EMPTY;
         end else if ((tok_phase == PH_PREFIX) || (tok_phase == PH_PRECMD)) begin
            o.status = ST_NO_CMD;
         end else begin
            o.status = ST_OK;
            o.arg_count = tok_args;
         end
         tok_phase = PH_LEAD;
         tok_args = '0;
      end
      return o;
   endfunction

   function automatic logic [7:0] pick_space();
      if ($urandom_range(2) == 0) return 8'(8'h09 + $urandom_range(4));
      return 8'h20;
   endfunction

   // Non-whitespace byte, mostly letters.
   function automatic logic [7:0] pick_word_byte();
      logic [7:0] b;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: b = 8'(8'h41 + $urandom_range(25) + ($urandom_range(1) ? 8'h20 : 8'h00));
         5: b = COLON;
         6: b = 8'(8'h80 + $urandom_range(127));
         7: b = 8'(8'h30 + $urandom_range(9));
         default: begin
            b = 8'($urandom_range(255, 1));
            if (is_space(b)) b = 8'h5F;
         end
      endcase
      return b;
   endfunction

   // Queue whole random lines until at least n_items bytes are queued.
   task automatic queue_random_lines(input int n_items);
      logic [7:0]   line [$];
      feed_row_type row;
      int           pushed;
      int           nargs;
      pushed = 0;
      while (pushed < n_items) begin
         line.delete();
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(3) == 0) line.push_back(pick_space());
            if ($urandom_range(2) == 0) begin
               line.push_back(COLON);
               repeat ($urandom_range(6)) line.push_back(pick_word_byte());
               repeat ($urandom_range(2, 1)) line.push_back(pick_space());
            end
            repeat ($urandom_range(6, 1)) line.push_back(pick_word_byte());
            nargs = ($urandom_range(99) < 30) ? $urandom_range(18, 12) : $urandom_range(5);
            repeat (nargs) begin
               repeat ($urandom_range(2, 1)) line.push_back(pick_space());
               repeat ($urandom_range(4, 1)) line.push_back(pick_word_byte());
            end
            if ($urandom_range(2) == 0) begin
               line.push_back(pick_space());
               line.push_back(COLON);
               repeat ($urandom_range(6)) begin
                  line.push_back(($urandom_range(3) == 0) ? pick_space() : pick_word_byte());
               end
            end
            if ($urandom_range(4) == 0) line.push_back(pick_space());
         end else begin
            repeat ($urandom_range(12, 1)) begin
               case ($urandom_range(3))
                  0: line.push_back(pick_space());
                  1: line.push_back(COLON);
                  default: line.push_back(8'($urandom_range(255, 1)));
               endcase
            end
         end
         foreach (line[i]) begin
            row.item.in_byte = line[i];
            row.item.last = (i == line.size() - 1);
            row.typed = 1'b0;
            row.want = NO_WANT;
            byte_feed.push_back(row);
         end
         pushed += line.size();
      end
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic wait_fed();
      while ((byte_feed.size() != 0) || req_valid) @(posedge clock);
   endtask

   // Offer the next queued byte once the current one is taken.
   always @(posedge clock) begin : sender
      feed_row_type row;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if ((byte_feed.size() != 0) && !sender_pause &&
             ($urandom_range(99) >= send_idle_pct)) begin
            row = byte_feed.pop_front();
            req_valid <= 1'b1;
            req_item <= row.item;
            cur_typed <= row.typed;
            cur_want <= row.want;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served = holds_served + 1;
         hold_left = 300;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type pred;
      if (reset) begin
         tok_phase = PH_LEAD;
         tok_args = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_tags.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_item);
               mismatch_count++;
            end else begin
               want = pending_tags.pop_front();
               check_field("token_class", 32'(want.token_class),
                           32'(rsp_item.token_class));
               check_field("arg_index", 32'(want.arg_index), 32'(rsp_item.arg_index));
               check_field("out_byte", 32'(want.out_byte), 32'(rsp_item.out_byte));
               check_field("line_done", 32'(want.line_done), 32'(rsp_item.line_done));
               check_field("status", 32'(want.status), 32'(rsp_item.status));
               check_field("arg_count", 32'(want.arg_count), 32'(rsp_item.arg_count));
            end
         end
         if (req_valid && req_ready) begin
            pred = tokenize_byte(req_item);
            pending_tags.push_back(cur_typed ? cur_want : pred);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("irc_line_tokenizer regression: fail");
      $finish;
   end

   initial begin : main
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) byte_feed.push_back(dir_rows[i]);
      wait_fed();

      queue_random_lines(400);
      // Hold the sender until the block has drained.
      while (byte_feed.size() > 200) @(posedge clock);
      sender_pause <= 1'b1;
      repeat (2) @(posedge clock);
      while (req_valid || (pending_tags.size() != 0)) @(posedge clock);
      sender_pause <= 1'b0;
      wait_fed();

      send_idle_pct <= 64;
      recv_idle_pct <= 26;
      queue_random_lines(400);
      wait_fed();

      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_requests <= hold_requests + 1;
      queue_random_lines(400);
      wait_fed();

      waited = 0;
      while ((pending_tags.size() != 0) && (waited < 2000)) begin
         @(posedge clock);
         waited++;
      end
      if (pending_tags.size() != 0) begin
         $display("%0t: %0d results never arrived, expected %h", $time,
                  pending_tags.size(), pending_tags[0]);
         mismatch_count++;
      end
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("irc_line_tokenizer regression: pass");
      end else begin
         $display("irc_line_tokenizer regression: fail");
      end
      $finish;
   end

endmodule
